// ----- design/pcs_pkg.sv -----
// shared types and codes for the priority counting semaphore
package pcs_pkg;

	localparam int unsigned MAX_ROWS = 8;
	localparam int unsigned ROW_SHIFT = 3;

	localparam logic [1:0] KIND_WAIT    = 2'd0;
	localparam logic [1:0] KIND_SIGNAL  = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BLOCKED   = 3'd1;
	localparam logic [2:0] ST_INT_ERR   = 3'd2;
	localparam logic [2:0] ST_TIMEOUT   = 3'd3;
	localparam logic [2:0] ST_SATURATED = 3'd4;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic       found;
		logic [2:0] row;
		logic [2:0] col;
	} waiter_t;

endpackage

// ----- design/pcs_prio_find.sv -----
// two-level lowest-set-bit search over the wait bitmaps
module pcs_prio_find
	import pcs_pkg::*;
(
	input  logic [7:0] group,
	input  logic [7:0] rows [MAX_ROWS],
	output waiter_t    top
);

	logic [2:0] grp_idx;
	logic [2:0] col_idx;
	logic [7:0] sel_row;

	always_comb begin
		grp_idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (group[i]) begin
				grp_idx = 3'(i);
			end
		end
	end

	assign sel_row = rows[grp_idx];

	always_comb begin
		col_idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (sel_row[i]) begin
				col_idx = 3'(i);
			end
		end
	end

	assign top.found = |group;
	assign top.row   = grp_idx;
	assign top.col   = col_idx;

endmodule

// ----- design/priority_counting_semaphore_unit.sv -----
// top level of the priority counting semaphore with a two-level wait bitmap
//
// a request is taken at a rising edge with start high and busy low; kind,
// task_prio and in_interrupt are sampled there into an input register
// at the next edge the result register loads and done is high for exactly
// one cycle with status, woken_valid, woken_prio and count_now; the
// receiver cannot stall, so a result is never held back
// a new request may be taken every cycle, since the count and bitmap update
// in the same cycle that the result register loads
// the count register is written through cfg_valid/cfg_ready/cfg_data,
// always ready; a write reloads the count and keeps the wait list
// reset clears the count, the wait bitmaps and the pipeline valid bits;
// busy is high for the first cycle after reset is released
// ROW_COUNT limits which priority rows can hold a waiter
module priority_counting_semaphore_unit
	import pcs_pkg::*;
#(
	parameter int unsigned ROW_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [5:0]  task_prio,
	input  logic        in_interrupt,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic        woken_valid,
	output logic [5:0]  woken_prio,
	output logic [15:0] count_now
);

	localparam logic [7:0] ROW_MASK = 8'((9'd1 << ROW_COUNT) - 9'd1);

	logic        busy_q;
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [5:0]  prio_s1;
	logic        intr_s1;

	logic [15:0] count_q;
	logic [7:0]  group_q;
	logic [7:0]  rows_q [MAX_ROWS];

	logic        done_q;
	logic [2:0]  status_q;
	logic        wvalid_q;
	logic [5:0]  wprio_q;

	waiter_t     top;
	logic [2:0]  row;
	logic [2:0]  col;
	logic        row_ok;
	logic        clr_en;
	logic [2:0]  clr_row;
	logic [2:0]  clr_col;
	logic [15:0] count_d;
	logic [7:0]  group_d;
	logic [7:0]  rows_d [MAX_ROWS];
	logic [2:0]  status_d;
	logic        wvalid_d;
	logic [5:0]  wprio_d;

	pcs_prio_find u_find (
		.group (group_q),
		.rows  (rows_q),
		.top   (top)
	);

	assign row    = prio_s1[5:3];
	assign col    = prio_s1[2:0];
	assign row_ok = {1'b0, row} < 4'(ROW_COUNT);

	always_comb begin
		count_d  = count_q;
		group_d  = group_q;
		rows_d   = rows_q;
		status_d = ST_OK;
		wvalid_d = 1'b0;
		wprio_d  = 6'd0;
		clr_en   = 1'b0;
		clr_row  = row;
		clr_col  = col;
		case (kind_s1)
			KIND_WAIT: begin
				if (intr_s1) begin
					status_d = ST_INT_ERR;
				end else if (count_q != 16'd0) begin
					count_d = count_q - 16'd1;
				end else if (!row_ok) begin
					status_d = ST_INT_ERR;
				end else begin
					rows_d[row][col] = 1'b1;
					group_d[row]     = 1'b1;
					status_d         = ST_BLOCKED;
				end
			end
			KIND_SIGNAL: begin
				if (top.found) begin
					wvalid_d = 1'b1;
					wprio_d  = {top.row, top.col};
					clr_en   = 1'b1;
					clr_row  = top.row;
					clr_col  = top.col;
				end else if (count_q == COUNT_MAX) begin
					status_d = ST_SATURATED;
				end else begin
					count_d = count_q + 16'd1;
				end
			end
			KIND_TIMEOUT: begin
				clr_en   = row_ok;
				status_d = ST_TIMEOUT;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		if (clr_en) begin
			rows_d[clr_row][clr_col] = 1'b0;
			if (rows_d[clr_row] == 8'd0) begin
				group_d[clr_row] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= 16'd0;
			group_q  <= 8'd0;
			for (int r = 0; r < MAX_ROWS; r++) begin
				rows_q[r] <= 8'd0;
			end
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= start && !busy_q;
			done_q   <= valid_s1;
			if (valid_s1) begin
				count_q <= count_d;
				group_q <= group_d & ROW_MASK;
				for (int r = 0; r < MAX_ROWS; r++) begin
					rows_q[r] <= ROW_MASK[r] ? rows_d[r] : 8'd0;
				end
			end
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			kind_s1 <= kind;
			prio_s1 <= task_prio;
			intr_s1 <= in_interrupt;
		end
		if (valid_s1) begin
			status_q <= status_d;
			wvalid_q <= wvalid_d;
			wprio_q  <= wprio_d;
		end
	end

	assign busy        = busy_q;
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign status      = status_q;
	assign woken_valid = wvalid_q;
	assign woken_prio  = wprio_q;
	assign count_now   = count_q;

`ifndef SYNTHESIS
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("request in flight produced no result");
	a_woken_prio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !woken_valid) |-> (woken_prio == 6'd0))
		else $error("woken_prio set without a released waiter");
	a_woken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && woken_valid) |-> (status == ST_OK))
		else $error("released waiter with non-ok status");
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_SATURATED) |-> (count_now == COUNT_MAX))
		else $error("saturation reported below full count");
	a_group_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(group_q == 8'd0) |-> ((rows_q[0] | rows_q[1] | rows_q[2] | rows_q[3]
			| rows_q[4] | rows_q[5] | rows_q[6] | rows_q[7]) == 8'd0))
		else $error("waiter recorded in a row without its group bit");
`endif

endmodule

// ----- tb/semaphore_checker.sv -----
// checker that predicts every semaphore request result and compares it with the unit's output
module semaphore_checker
	import pcs_pkg::*;
#(
	parameter int unsigned ROW_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [5:0]  task_prio,
	input  logic        in_interrupt,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic        woken_valid,
	input  logic [5:0]  woken_prio,
	input  logic [15:0] count_now,
	output int unsigned pending,
	output int unsigned mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  status;
		logic        woken_valid;
		logic [5:0]  woken_prio;
		logic [15:0] count_now;
	} sem_result_t;

	logic [15:0] sem_count;
	logic [7:0]  wait_group;
	logic [7:0]  wait_rows [MAX_ROWS];
	sem_result_t expected_results [$];

	function automatic logic [2:0] lowest_set(input logic [7:0] v);
		logic [2:0] idx;
		idx = '0;
		for (int i = 7; i >= 0; i--)
			if (v[i])
				idx = 3'(i);
		return idx;
	endfunction

	function automatic void clear_waiter(input logic [2:0] row, input logic [2:0] col);
		if (32'(row) < ROW_COUNT) begin
			wait_rows[row][col] = 1'b0;
			if (wait_rows[row] == '0)
				wait_group[row] = 1'b0;
		end
	endfunction

	function automatic sem_result_t apply_request(input logic [1:0] k, input logic [5:0] prio,
			input logic intr);
		sem_result_t r;
		logic [2:0] row;
		logic [2:0] col;
		r = '0;
		row = prio[5:3];
		col = prio[2:0];
		case (k)
			KIND_WAIT: begin
				if (intr) begin
					r.status = ST_INT_ERR;
				end else if (sem_count != '0) begin
					sem_count = sem_count - 16'd1;
					r.status = ST_OK;
				end else if (32'(row) >= ROW_COUNT) begin
					r.status = ST_INT_ERR;
				end else begin
					wait_rows[row][col] = 1'b1;
					wait_group[row] = 1'b1;
					r.status = ST_BLOCKED;
				end
			end
			KIND_SIGNAL: begin
				if (wait_group != '0) begin
					row = lowest_set(wait_group);
					col = lowest_set(wait_rows[row]);
					r.woken_valid = 1'b1;
					r.woken_prio = {row, col};
					clear_waiter(row, col);
					r.status = ST_OK;
				end else if (sem_count == COUNT_MAX) begin
					r.status = ST_SATURATED;
				end else begin
					sem_count = sem_count + 16'd1;
					r.status = ST_OK;
				end
			end
			KIND_TIMEOUT: begin
				clear_waiter(row, col);
				r.status = ST_TIMEOUT;
			end
			default: r.status = ST_OK;
		endcase
		r.count_now = sem_count;
		return r;
	endfunction

	function automatic void compare_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sem_result_t exp_r;
		if (!arst_n) begin
			sem_count = '0;
			wait_group = '0;
			foreach (wait_rows[i])
				wait_rows[i] = '0;
			expected_results.delete();
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request outstanding, %s %0d count %0d",
						$time, "expected none actual status", status, count_now);
				end else begin
					exp_r = expected_results.pop_front();
					compare_field("status", 32'(exp_r.status), 32'(status));
					compare_field("woken_valid", 32'(exp_r.woken_valid), 32'(woken_valid));
					compare_field("woken_prio", 32'(exp_r.woken_prio), 32'(woken_prio));
					compare_field("count_now", 32'(exp_r.count_now), 32'(count_now));
				end
			end
			if (cfg_valid && cfg_ready)
				sem_count = cfg_data;
			if (start && !busy)
				expected_results.push_back(apply_request(kind, task_prio, in_interrupt));
		end
		pending = expected_results.size();
	end

endmodule

// ----- tb/tb.sv -----
// bench top: clock, reset, request stimulus and verdict for the priority counting semaphore
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcs_pkg::*;

	localparam int unsigned ROWS        = 8;
	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam int unsigned PHASES      = 12;
	localparam int unsigned PHASE_ITEMS = 160;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  kind = '0;
	logic [5:0]  task_prio = '0;
	logic        in_interrupt = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        busy;
	logic        cfg_ready;
	logic        done;
	logic [2:0]  status;
	logic        woken_valid;
	logic [5:0]  woken_prio;
	logic [15:0] count_now;
	int unsigned pending;
	int unsigned mismatches;
	int unsigned stall_cycles;

	always #5 clk = ~clk;

	priority_counting_semaphore_unit #(
		.ROW_COUNT(ROWS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.task_prio   (task_prio),
		.in_interrupt(in_interrupt),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.woken_valid (woken_valid),
		.woken_prio  (woken_prio),
		.count_now   (count_now)
	);

	semaphore_checker #(
		.ROW_COUNT(ROWS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.task_prio   (task_prio),
		.in_interrupt(in_interrupt),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.woken_valid (woken_valid),
		.woken_prio  (woken_prio),
		.count_now   (count_now),
		.pending     (pending),
		.mismatches  (mismatches)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] k, input logic [5:0] p, input logic intr);
		logic took;
		start <= 1'b1;
		kind <= k;
		task_prio <= p;
		in_interrupt <= intr;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic write_count(input logic [15:0] v);
		logic took;
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned idle_pct);
		logic [5:0]  hot [8];
		logic [1:0]  k;
		logic [5:0]  p;
		int unsigned roll;
		foreach (hot[i])
			hot[i] = 6'($urandom_range(0, 63));
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			while ($urandom_range(0, 99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
			roll = $urandom_range(0, 99);
			if (roll < 40)
				k = KIND_WAIT;
			else if (roll < 75)
				k = KIND_SIGNAL;
			else if (roll < 95)
				k = KIND_TIMEOUT;
			else
				k = KIND_UNUSED;
			if ($urandom_range(0, 1) == 1)
				p = hot[3'($urandom_range(0, 7))];
			else
				p = 6'($urandom_range(0, 63));
			send_item(k, p, $urandom_range(0, 9) == 0);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// count is zero after reset, so waits block
		send_item(KIND_WAIT, 6'd63, 1'b0);
		send_item(KIND_WAIT, 6'd0, 1'b0);
		send_item(KIND_WAIT, 6'd0, 1'b0);
		send_item(KIND_WAIT, 6'd56, 1'b0);
		send_item(KIND_WAIT, 6'd9, 1'b1);
		send_item(KIND_TIMEOUT, 6'd63, 1'b0);
		send_item(KIND_TIMEOUT, 6'd5, 1'b0);
		send_item(KIND_SIGNAL, 6'd0, 1'b0);
		send_item(KIND_SIGNAL, 6'd0, 1'b0);
		send_item(KIND_SIGNAL, 6'd0, 1'b0);
		send_item(KIND_UNUSED, 6'd63, 1'b1);
		send_item(KIND_WAIT, 6'd9, 1'b0);
		send_item(KIND_WAIT, 6'd9, 1'b0);
		send_item(KIND_SIGNAL, 6'd0, 1'b1);
		drain();

		// full count: saturation
		write_count(COUNT_MAX);
		send_item(KIND_SIGNAL, 6'd0, 1'b0);
		send_item(KIND_WAIT, 6'd0, 1'b0);
		send_item(KIND_SIGNAL, 6'd0, 1'b0);
		send_item(KIND_SIGNAL, 6'd0, 1'b0);
		send_item(KIND_TIMEOUT, 6'd42, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph % 4)
				0: write_count(16'd0);
				1: write_count(COUNT_MAX);
				2: write_count(16'($urandom_range(0, 3)));
				default: write_count(16'($urandom_range(0, 65535)));
			endcase
			case (ph % 3)
				0: run_phase(0);
				1: run_phase(59);
				default: run_phase(8);
			endcase
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
